/* sv/sorted_timed_event_queue_unit_macros.svh */
// Assertion macros for the sorted timed event queue.
`ifndef SORTED_TIMED_EVENT_QUEUE_UNIT_MACROS_SVH
`define SORTED_TIMED_EVENT_QUEUE_UNIT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define STEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Property that must hold on every clock edge, including during reset.
`define STEQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* sv/steq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steq_pkg
// Types and codes shared by the sorted timed event queue modules.
// ----------------------------------------------------------------------------
package steq_pkg;

    localparam int FIELD_TIME_BITS = 32;
    localparam int FIELD_TAG_BITS  = 16;

    typedef enum logic [0:0] {
        FUNC_INSERT  = 1'b0,
        FUNC_ADVANCE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_NONE    = 2'd2
    } result_kind_t;

    typedef struct packed {
        logic [0:0]                 func;
        logic [FIELD_TAG_BITS-1:0]  event_tag;
        logic [FIELD_TIME_BITS-1:0] run_time;
        logic [FIELD_TIME_BITS-1:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                 result_kind;
        logic [FIELD_TAG_BITS-1:0]  due_tag;
        logic                       dropped;
        logic                       last_of_run;
        logic                       next_valid;
        logic [FIELD_TIME_BITS-1:0] next_time;
    } out_item_t;

endpackage

/* sv/sorted_timed_event_queue_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timed_event_queue_unit
// Timer event queue kept sorted by run time, with insert and advance beats.
// ----------------------------------------------------------------------------
// An insert beat in the back end has every slot compare its run
// time with the new one in parallel, and the later entries shift up by one. An
// advance beat releases one due event per cycle from the head slot while the
// result stage is free, and gives a single result when none is due.
// A two-entry input queue and a registered result stage decouple the sides.
// There is no clearing pass at reset.
module sorted_timed_event_queue_unit #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  steq_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output steq_pkg::out_item_t m_item
);
    import steq_pkg::*;

    logic     cmd_valid;
    logic     cmd_ready;
    in_item_t cmd_item;

    steq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item)
    );

    steq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

/* sv/steq_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steq_front
// Accepts input beats and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module steq_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  steq_pkg::in_item_t s_item,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output steq_pkg::in_item_t cmd_item
);
    import steq_pkg::*;

    in_item_t   fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign s_ready   = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd_item  = fifo_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= s_item;
        end
    end

endmodule

/* sv/steq_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steq_back
// Sorted slot array with parallel insertion and one-per-cycle release while the result stage is free.
// ----------------------------------------------------------------------------
module steq_back #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  steq_pkg::in_item_t cmd_item,
    output logic               m_valid,
    input  logic               m_ready,
    output steq_pkg::out_item_t m_item
);
    import steq_pkg::*;

    localparam int TIME_BITS = FIELD_TIME_BITS;
    localparam int TAG_BITS  = FIELD_TAG_BITS;
    localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE    = 2'b01,
        ST_RELEASE = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [TIME_BITS-1:0]  slot_time_reg [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]   slot_tag_reg  [QUEUE_DEPTH];
    logic [CNT_BITS-1:0]   count_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic                  out_valid_reg;
    out_item_t             out_reg;

    logic [TIME_BITS-1:0]  in_time;
    logic [TAG_BITS-1:0]   in_tag;
    logic [TIME_BITS-1:0]  in_now;
    logic [QUEUE_DEPTH-1:0] later;
    logic                  full;
    logic                  out_free;
    logic                  head_due;
    logic                  do_insert, do_advance, do_pop;
    logic [CNT_BITS-1:0]   count_after_pop;
    logic                  nv_after_pop;
    logic [TIME_BITS-1:0]  nt_after_pop;
    logic                  nv_after_ins;
    logic [TIME_BITS-1:0]  nt_after_ins;
    logic                  next_due;
    logic [TIME_BITS-1:0]  cmp_now;
    logic [QUEUE_DEPTH-1:0] due_vec;
    logic                  fin_valid;
    logic [TIME_BITS-1:0]  fin_time;

    assign in_time  = cmd_item.run_time[TIME_BITS-1:0];
    assign in_tag   = cmd_item.event_tag[TAG_BITS-1:0];
    assign in_now   = cmd_item.now_time[TIME_BITS-1:0];
    assign full     = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_reg;
    assign cmp_now  = (state_reg == ST_IDLE) ? in_now : now_reg;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            later[i] = (CNT_BITS'(i) < count_reg) && (in_time < slot_time_reg[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            due_vec[i] = (CNT_BITS'(i) < count_reg) && (slot_time_reg[i] < cmp_now);
        end
    end

    // The earliest entry left once the whole run of due events has gone.
    always_comb begin
        fin_valid = 1'b0;
        fin_time  = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if ((CNT_BITS'(i) < count_reg) && !due_vec[i] &&
                (i == 0 || due_vec[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH])) begin
                fin_valid = 1'b1;
                fin_time  = fin_time | slot_time_reg[i];
            end
        end
    end

    assign cmd_ready  = (state_reg == ST_IDLE) && out_free;
    assign do_insert  = cmd_ready && cmd_valid && (cmd_item.func == FUNC_INSERT) && !full;
    assign do_advance = cmd_ready && cmd_valid && (cmd_item.func == FUNC_ADVANCE);
    assign head_due   = (count_reg != '0) &&
                        (slot_time_reg[0] < (state_reg == ST_IDLE ? in_now : now_reg));
    assign do_pop     = head_due && out_free &&
                        (do_advance || state_reg == ST_RELEASE);

    assign count_after_pop = count_reg - CNT_BITS'(1);
    assign nv_after_pop    = (count_after_pop != '0);
    assign nt_after_pop    = (QUEUE_DEPTH > 1 && nv_after_pop) ?
                             slot_time_reg[(QUEUE_DEPTH > 1) ? 1 : 0] : '0;
    assign next_due        = nv_after_pop &&
                             (nt_after_pop < (state_reg == ST_IDLE ? in_now : now_reg));
    assign nv_after_ins    = full ? (count_reg != '0) : 1'b1;
    assign nt_after_ins    = full ? slot_time_reg[0] :
                             ((count_reg == '0 || later[0]) ? in_time : slot_time_reg[0]);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (do_pop && next_due) begin
                    state_next = ST_RELEASE;
                end
            end
            ST_RELEASE: begin
                if (do_pop && !next_due) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (do_insert) begin
                count_reg <= count_reg + CNT_BITS'(1);
            end else if (do_pop) begin
                count_reg <= count_after_pop;
            end
            if (cmd_ready && cmd_valid) begin
                out_valid_reg <= 1'b1;
            end else if (do_pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_advance) begin
            now_reg <= in_now;
        end
        if (do_insert) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (later[i]) begin
                    if (i + 1 < QUEUE_DEPTH) begin
                        slot_time_reg[(i + 1) % QUEUE_DEPTH] <= slot_time_reg[i];
                        slot_tag_reg[(i + 1) % QUEUE_DEPTH]  <= slot_tag_reg[i];
                    end
                    if (i == 0 || !later[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH]) begin
                        slot_time_reg[i] <= in_time;
                        slot_tag_reg[i]  <= in_tag;
                    end
                end else if (CNT_BITS'(i) == count_reg && (i == 0 ||
                             !later[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH])) begin
                    slot_time_reg[i] <= in_time;
                    slot_tag_reg[i]  <= in_tag;
                end
            end
        end else if (do_pop) begin
            for (int i = 0; i + 1 < QUEUE_DEPTH; i++) begin
                slot_time_reg[i] <= slot_time_reg[i + 1];
                slot_tag_reg[i]  <= slot_tag_reg[i + 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_pop) begin
            out_reg.result_kind <= KIND_RELEASE;
            out_reg.due_tag     <= FIELD_TAG_BITS'(slot_tag_reg[0]);
            out_reg.dropped     <= 1'b0;
            out_reg.last_of_run <= !next_due;
            out_reg.next_valid  <= fin_valid;
            out_reg.next_time   <= FIELD_TIME_BITS'(fin_time);
        end else if (cmd_ready && cmd_valid) begin
            out_reg.due_tag     <= '0;
            out_reg.last_of_run <= 1'b1;
            if (cmd_item.func == FUNC_INSERT) begin
                out_reg.result_kind <= KIND_INSERT;
                out_reg.dropped     <= full;
                out_reg.next_valid  <= nv_after_ins;
                out_reg.next_time   <= nv_after_ins ? FIELD_TIME_BITS'(nt_after_ins) : '0;
            end else begin
                out_reg.result_kind <= KIND_NONE;
                out_reg.dropped     <= 1'b0;
                out_reg.next_valid  <= (count_reg != '0);
                out_reg.next_time   <= (count_reg != '0) ?
                                       FIELD_TIME_BITS'(slot_time_reg[0]) : '0;
            end
        end
    end

endmodule

/* sv/steq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steq_checker
// Port-level checks on the result channel of the event queue.
// ----------------------------------------------------------------------------
`include "sorted_timed_event_queue_unit_macros.svh"

module steq_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input steq_pkg::out_item_t m_item
);
    import steq_pkg::*;

    `STEQ_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_item), "result beat changed while stalled")
    `STEQ_ASSERT(a_kind, m_valid |-> m_item.result_kind != 2'd3, "unknown result kind")
    `STEQ_ASSERT(a_single, m_valid && m_item.result_kind != KIND_RELEASE |-> m_item.last_of_run, "single result not marked last")
    `STEQ_ASSERT(a_nexttime, m_valid && !m_item.next_valid |-> m_item.next_time == '0, "next time set with empty queue")
    `STEQ_ASSERT_ALWAYS(a_reset, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind sorted_timed_event_queue_unit steq_checker u_steq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
